// ----- src/xrg_pkg.sv -----
// ----------------------------------------------------------------------------
// xrg_pkg: shared types and constants of the xorshift32 range generator
// Word widths, shift amounts, the reset seed, the payload structs and the
// control/status structs between the sequencer and the modulo unit.
// ----------------------------------------------------------------------------
package xrg_pkg;

   localparam int WordWidth = 32;
   localparam int SpanWidth = WordWidth + 1;
   localparam int CountWidth = $clog2(WordWidth);

   localparam int ShiftA = 13;
   localparam int ShiftB = 17;
   localparam int ShiftC = 5;

   localparam logic [WordWidth-1:0] ResetSeed = 32'd42;

   typedef struct packed {
      logic signed [WordWidth-1:0] range_low;
      logic signed [WordWidth-1:0] range_high;
   } req_type;

   typedef struct packed {
      logic        [WordWidth-1:0] raw_word;
      logic signed [WordWidth-1:0] ranged_value;
      logic                        range_error;
   } rsp_type;

   typedef struct packed {
      logic                 start;
      logic [WordWidth-1:0] dividend;
      logic [SpanWidth-1:0] divisor;
   } div_ctl_type;

   typedef struct packed {
      logic                 busy;
      logic                 done;
      logic [SpanWidth-1:0] remainder;
   } div_stat_type;

   function automatic logic [WordWidth-1:0] advance_word(input logic [WordWidth-1:0] w);
      logic [WordWidth-1:0] t;
      t = w ^ (w << ShiftA);
      t = t ^ (t >> ShiftB);
      t = t ^ (t << ShiftC);
      return t;
   endfunction

endpackage

// ----- src/xrg_mod_unit.sv -----
// ----------------------------------------------------------------------------
// xrg_mod_unit: radix-2 restoring modulo unit
// Reduces a 32-bit magnitude modulo a 33-bit span, one dividend bit per
// cycle through a single shared subtract-and-compare stage.
// ----------------------------------------------------------------------------
module xrg_mod_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  xrg_pkg::div_ctl_type  ctl,
   output xrg_pkg::div_stat_type stat
);

   logic [xrg_pkg::SpanWidth-1:0]  rem_ff, rem_in;
   logic [xrg_pkg::WordWidth-1:0]  dvd_ff, dvd_in;
   logic [xrg_pkg::SpanWidth-1:0]  dvs_ff, dvs_in;
   logic [xrg_pkg::CountWidth-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;

   logic [xrg_pkg::SpanWidth:0] trial;
   logic [xrg_pkg::SpanWidth:0] diff;

   localparam logic [xrg_pkg::CountWidth-1:0] LastCount =
      xrg_pkg::CountWidth'(xrg_pkg::WordWidth - 1);

   // shift in the next dividend bit, keep the difference if it did not go negative
   assign trial = {rem_ff, dvd_ff[xrg_pkg::WordWidth-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         rem_in  = '0;
         dvd_in  = ctl.dividend;
         dvs_in  = ctl.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = diff[xrg_pkg::SpanWidth] ? trial[xrg_pkg::SpanWidth-1:0]
                                           : diff[xrg_pkg::SpanWidth-1:0];
         dvd_in = {dvd_ff[xrg_pkg::WordWidth-2:0], 1'b0};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == LastCount) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      dvs_ff <= dvs_in;
   end

   assign stat.busy      = busy_ff;
   assign stat.done      = done_ff;
   assign stat.remainder = rem_ff;

endmodule

// ----- src/xorshift32_range_generator_unit.sv -----
// Each request word is accepted in idle, passes a set-up state and the 32-step
// modulo unit, and is handed off from the done state to the response register
// once it is free; no new request is taken until the sequencer is idle again.
// Reset (synchronous, active high) loads the generator word with 42 and
// empties the sequencer and the response register.
// ----------------------------------------------------------------------------
// xorshift32_range_generator_unit: xorshift32 generator with range folding
// Advances the generator word on each request, returns it raw and reduced
// into [range_low, range_high]; a seed write reloads the generator word.
// ----------------------------------------------------------------------------
module xorshift32_range_generator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  xrg_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output xrg_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [xrg_pkg::WordWidth-1:0]      csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_SETUP  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_DONE   = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [xrg_pkg::WordWidth-1:0]        word_ff, word_in;
   logic signed [xrg_pkg::WordWidth-1:0] lo_ff, lo_in;
   logic signed [xrg_pkg::WordWidth-1:0] hi_ff, hi_in;
   logic                                 err_ff, err_in;
   logic                                 rsp_valid_ff, rsp_valid_in;
   xrg_pkg::rsp_type                     rsp_ff, rsp_in;

   logic                          req_accept;
   logic                          csr_write;
   logic                          out_free;
   logic [xrg_pkg::SpanWidth:0]   diff_wide;
   logic [xrg_pkg::SpanWidth-1:0] span;
   logic [xrg_pkg::WordWidth-1:0] mag;

   xrg_pkg::div_ctl_type  div_ctl;
   xrg_pkg::div_stat_type div_stat;

   xrg_mod_unit u_mod (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   // hold off requests while a seed write is pending so the write lands first
   assign req_stall  = (state_ff != ST_IDLE) || csr_valid;
   assign csr_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_write  = csr_valid && csr_ready;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // span at 33 bits covers the full signed range
   assign diff_wide = {{2{hi_ff[xrg_pkg::WordWidth-1]}}, hi_ff}
                    - {{2{lo_ff[xrg_pkg::WordWidth-1]}}, lo_ff};
   assign span      = diff_wide[xrg_pkg::SpanWidth-1:0] + 1'b1;
   // two's complement of the most negative word reads as 2^31 unsigned
   assign mag       = word_ff[xrg_pkg::WordWidth-1] ? (~word_ff + 1'b1) : word_ff;

   assign div_ctl.start    = (state_ff == ST_SETUP);
   assign div_ctl.dividend = mag;
   assign div_ctl.divisor  = span;

   always_comb begin
      state_in     = state_ff;
      word_in      = word_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (csr_write) begin
               word_in = csr_data;
            end else if (req_accept) begin
               word_in  = xrg_pkg::advance_word(word_ff);
               lo_in    = req_data.range_low;
               hi_in    = req_data.range_high;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            err_in   = (hi_ff < lo_ff);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in.raw_word     = word_ff;
               rsp_in.range_error  = err_ff;
               rsp_in.ranged_value = err_ff ? lo_ff
                  : $signed(div_stat.remainder[xrg_pkg::WordWidth-1:0] + lo_ff);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         word_ff      <= xrg_pkg::ResetSeed;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      err_ff <= err_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef SYNTH
   a_accept_to_setup: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_SETUP)
      else $error("accepted request did not enter set-up");

   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == ST_DIVIDE)
      else $error("modulo unit finished outside the divide state");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response word appeared without a finished item");

   a_unit_busy_divide: assert property (@(posedge clock) disable iff (reset)
      div_stat.busy |-> state_ff == ST_DIVIDE)
      else $error("modulo unit busy outside the divide state");
`endif

endmodule

// ----- tb/xorshift32_range_generator_unit_tb.sv -----
// ----------------------------------------------------------------------------
// xorshift32_range_generator_unit_tb: self-checking bench for the range unit
// Drives range request words through a burst-idling driver, stalls the
// response side at random and checks every response word against a local
// model of the xorshift word and the range fold. The seed register is
// reloaded between phases: zero, all ones, one, random and a seed that makes
// the next word the most negative value.
// ----------------------------------------------------------------------------
module xorshift32_range_generator_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QuietLimit = 2000;
   localparam int ReportLimit = 10;
   localparam logic signed [xrg_pkg::WordWidth-1:0] LowestValue = 32'sh8000_0000;
   localparam logic signed [xrg_pkg::WordWidth-1:0] HighestValue = 32'sh7fff_ffff;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   xrg_pkg::req_type              req_data = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   xrg_pkg::rsp_type              rsp_data;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [xrg_pkg::WordWidth-1:0] csr_data = '0;

   xrg_pkg::req_type              range_backlog[$];
   xrg_pkg::rsp_type              predicted_results[$];
   logic [xrg_pkg::WordWidth-1:0] shadow_word;
   logic                          req_fired = 1'b0;
   logic                          calm = 1'b0;
   int                            sender_gap = 0;
   int                            stall_left = 0;
   int                            quiet_cycles = 0;
   int                            mismatch_count = 0;

   xorshift32_range_generator_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // Fold the signed word to |word| mod span, then offset by range_low.
   function automatic xrg_pkg::rsp_type fold_into_range(
      input xrg_pkg::req_type r,
      input logic [xrg_pkg::WordWidth-1:0] w);
      xrg_pkg::rsp_type result;
      longint  lo;
      longint  hi;
      longint  signed_word;
      longint  magnitude;
      longint  folded;
      lo = r.range_low;
      hi = r.range_high;
      result.raw_word = w;
      if (hi < lo) begin
         result.range_error = 1'b1;
         result.ranged_value = r.range_low;
      end else begin
         signed_word = $signed(w);
         magnitude = (signed_word < 0) ? -signed_word : signed_word;
         folded = (magnitude % (hi - lo + 1)) + lo;
         result.range_error = 1'b0;
         result.ranged_value = folded[xrg_pkg::WordWidth-1:0];
      end
      return result;
   endfunction

   task automatic queue_request(input logic signed [xrg_pkg::WordWidth-1:0] lo,
                                input logic signed [xrg_pkg::WordWidth-1:0] hi);
      xrg_pkg::req_type r;
      r.range_low = lo;
      r.range_high = hi;
      range_backlog.push_back(r);
   endtask

   task automatic queue_random_requests(input int count);
      longint                        lo;
      longint                        hi;
      longint                        swap;
      logic [xrg_pkg::WordWidth-1:0] pick;
      for (int n = 0; n < count; n++) begin
         lo = $signed($urandom());
         hi = $signed($urandom());
         case ($urandom_range(0, 9))
            0: begin
               // inverted range
               if (hi > lo) begin
                  swap = lo;
                  lo = hi;
                  hi = swap;
               end
            end
            1: begin
               for (int side = 0; side < 2; side++) begin
                  case ($urandom_range(0, 4))
                     0: pick = LowestValue;
                     1: pick = HighestValue;
                     2: pick = '0;
                     3: pick = '1;
                     default: pick = $urandom();
                  endcase
                  if (side == 0) lo = $signed(pick);
                  else hi = $signed(pick);
               end
            end
            2, 3, 4: hi = lo + $urandom_range(0, 20);
            5, 6: hi = lo + $urandom_range(0, 100000);
            default: begin
               if (hi < lo) begin
                  swap = lo;
                  lo = hi;
                  hi = swap;
               end
            end
         endcase
         if (hi > HighestValue) hi = HighestValue;
         queue_request(lo[xrg_pkg::WordWidth-1:0], hi[xrg_pkg::WordWidth-1:0]);
      end
   endtask

   task automatic drain_all;
      do @(posedge clock);
      while (range_backlog.size() != 0 || req_valid || predicted_results.size() != 0);
   endtask

   task automatic write_seed(input logic [xrg_pkg::WordWidth-1:0] seed);
      drain_all();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= seed;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      logic [xrg_pkg::WordWidth-1:0] edge_seed;
      logic [xrg_pkg::WordWidth-1:0] unwound;
      // Unwind the three xorshift stages so the next word is 0x8000_0000.
      edge_seed = 32'h8000_0000;
      unwound = edge_seed;
      for (int k = xrg_pkg::ShiftC; k < xrg_pkg::WordWidth; k += xrg_pkg::ShiftC)
         unwound ^= edge_seed << k;
      edge_seed = unwound ^ (unwound >> xrg_pkg::ShiftB);
      edge_seed = edge_seed ^ (edge_seed << xrg_pkg::ShiftA)
                ^ (edge_seed << (2 * xrg_pkg::ShiftA));

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset seed, extreme ranges
      queue_request(LowestValue, HighestValue);
      queue_request(0, 0);
      queue_request(HighestValue, HighestValue);
      queue_request(LowestValue, LowestValue);
      queue_request(LowestValue, LowestValue + 1);
      queue_request(-1, 1);
      queue_request(5, 4);
      queue_request(HighestValue, LowestValue);
      queue_request(0, HighestValue);
      queue_request(LowestValue, -1);
      queue_request(-10, -3);
      queue_request(1, 6);
      queue_request(HighestValue - 1, HighestValue);

      // zero seed sticks at zero
      write_seed('0);
      queue_request(LowestValue, HighestValue);
      queue_request(-3, 3);
      queue_request(7, -7);

      // most negative word against a full and a narrow range
      write_seed(edge_seed);
      queue_request(LowestValue, HighestValue);
      write_seed(edge_seed);
      queue_request(-5, 9);
      write_seed(edge_seed);
      queue_request(0, 0);

      write_seed('1);
      queue_random_requests(500);
      // hold the sender until every response is back
      drain_all();
      queue_random_requests(250);

      write_seed($urandom());
      queue_random_requests(650);

      write_seed(32'd1);
      calm = 1'b1;
      queue_random_requests(600);

      drain_all();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && predicted_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   // Driver: advance only after the current word was taken.
   always @(negedge clock) begin
      if (!req_valid || req_fired) begin
         if (sender_gap != 0) begin
            sender_gap <= sender_gap - 1;
            req_valid <= 1'b0;
         end else if (!calm && range_backlog.size() != 0 && $urandom_range(0, 5) == 0) begin
            sender_gap <= $urandom_range(0, 3);
            req_valid <= 1'b0;
         end else if (range_backlog.size() != 0) begin
            req_data <= range_backlog.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 3);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin : monitor
      xrg_pkg::rsp_type want;
      logic             took_any;
      if (reset) begin
         shadow_word = xrg_pkg::ResetSeed;
         req_fired <= 1'b0;
         quiet_cycles = 0;
      end else begin
         took_any = 1'b0;
         req_fired <= req_valid && !req_stall;
         if (csr_valid && csr_ready) begin
            shadow_word = csr_data;
            took_any = 1'b1;
         end
         if (req_valid && !req_stall) begin
            shadow_word = shadow_word ^ (shadow_word << xrg_pkg::ShiftA);
            shadow_word = shadow_word ^ (shadow_word >> xrg_pkg::ShiftB);
            shadow_word = shadow_word ^ (shadow_word << xrg_pkg::ShiftC);
            predicted_results.push_back(fold_into_range(req_data, shadow_word));
            took_any = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            took_any = 1'b1;
            if (predicted_results.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("%0t: unexpected response word raw=%h ranged=%0d err=%b",
                           $realtime, rsp_data.raw_word, rsp_data.ranged_value,
                           rsp_data.range_error);
            end else begin
               want = predicted_results.pop_front();
               if (rsp_data.raw_word !== want.raw_word ||
                   rsp_data.ranged_value !== want.ranged_value ||
                   rsp_data.range_error !== want.range_error) begin
                  mismatch_count++;
                  if (mismatch_count <= ReportLimit)
                     $display({"%0t: expected raw=%h ranged=%0d err=%b, ",
                               "got raw=%h ranged=%0d err=%b"},
                              $realtime, want.raw_word, want.ranged_value, want.range_error,
                              rsp_data.raw_word, rsp_data.ranged_value, rsp_data.range_error);
               end
            end
         end
         if (took_any) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QuietLimit) begin
               $display("SCOREBOARD MISMATCH");
               $finish;
            end
         end
      end
   end

endmodule
